@@ rtl/core/sv39ptw_pkg.sv @@
// Shared types, constants and helpers for the Sv39 page table walker.
// No dependencies; every other file in rtl/core refers to this package.

package sv39ptw_pkg;

    localparam int VA_BITS    = 38;
    localparam int VA_W       = 39;
    localparam int PPN_W      = 44;
    localparam int PA_W       = 56;
    localparam int PTE_W      = 64;
    localparam int VPN_IDX_W  = 9;
    localparam int PAGE_SHIFT = 12;

    localparam int PTE_VALID_BIT = 0;
    localparam int PTE_USER_BIT  = 4;
    localparam int PTE_PPN_LSB   = 10;

    typedef enum logic [1:0] {
        LVL_0    = 2'd0,
        LVL_1    = 2'd1,
        LVL_2    = 2'd2,
        LVL_NONE = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        FLT_NONE       = 3'd0,
        FLT_VA_RANGE   = 3'd1,
        FLT_NO_TABLE   = 3'd2,
        FLT_LEAF_INVAL = 3'd3,
        FLT_NOT_USER   = 3'd4,
        FLT_UNEXP_RESP = 3'd5
    } fault_t;

    localparam logic FUNC_REQUEST  = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    // Walk state carried between beats
    typedef struct packed {
        logic             busy;
        logic [1:0]       level;
        logic [VA_W-1:0]  va;
        logic [1:0]       depth;
    } walk_state_t;

    // One result beat
    typedef struct packed {
        logic [1:0]       kind;
        logic [PA_W-1:0]  phys_addr;
        logic [2:0]       fault_code;
    } walk_result_t;

    // Select the 9-bit table index of the virtual address for a level
    function automatic logic [VPN_IDX_W-1:0] vpn_index(input logic [1:0] level,
                                                       input logic [VA_W-1:0] va);
        logic [VPN_IDX_W-1:0] idx;
        idx = '0;
        case (level)
            LVL_0:   idx = va[PAGE_SHIFT +: VPN_IDX_W];
            LVL_1:   idx = va[PAGE_SHIFT + VPN_IDX_W +: VPN_IDX_W];
            LVL_2:   idx = va[PAGE_SHIFT + 2*VPN_IDX_W +: VPN_IDX_W];
            default: idx = '0;
        endcase
        return idx;
    endfunction

    // Physical address of the PTE: table base plus index times eight
    function automatic logic [PA_W-1:0] pte_address(input logic [PPN_W-1:0] table_ppn,
                                                    input logic [1:0] level,
                                                    input logic [VA_W-1:0] va);
        return {table_ppn, vpn_index(level, va), 3'b000};
    endfunction

endpackage

@@ rtl/core/sv39ptw_if.sv @@
// Valid/ready channel interfaces for the walker: lookup/response beats in,
// result beats out. Depends on sv39ptw_pkg for field widths.

interface sv39ptw_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [sv39ptw_pkg::VA_W-1:0]    virt_addr;
    logic [1:0]                      stop_depth;
    logic [sv39ptw_pkg::PTE_W-1:0]   pte_word;

    modport source (output valid, func, virt_addr, stop_depth, pte_word, input ready);
    modport sink   (input valid, func, virt_addr, stop_depth, pte_word, output ready);
endinterface

interface sv39ptw_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [sv39ptw_pkg::PA_W-1:0]    phys_addr;
    logic [2:0]                      fault_code;

    modport source (output valid, kind, phys_addr, fault_code, input ready);
    modport sink   (input valid, kind, phys_addr, fault_code, output ready);
endinterface

@@ rtl/core/sv39ptw_step.sv @@
// Combinational step of the walk: one beat plus current state gives the
// next state and one result. Depends on sv39ptw_pkg.

module sv39ptw_step
(
    input  logic                              func,
    input  logic [sv39ptw_pkg::VA_W-1:0]      virt_addr,
    input  logic [1:0]                        stop_depth,
    input  logic [sv39ptw_pkg::PTE_W-1:0]     pte_word,
    input  logic [sv39ptw_pkg::PPN_W-1:0]     root_ppn,
    input  sv39ptw_pkg::walk_state_t          state_cur,
    output sv39ptw_pkg::walk_state_t          state_next,
    output sv39ptw_pkg::walk_result_t         result
);

    logic                              va_oob;
    logic                              is_final;
    logic [1:0]                        lvl_dec;
    logic [sv39ptw_pkg::PPN_W-1:0]     pte_ppn;

    assign va_oob   = (virt_addr >> sv39ptw_pkg::VA_BITS) != '0;
    assign lvl_dec  = state_cur.level - 2'd1;
    assign pte_ppn  = pte_word[sv39ptw_pkg::PTE_PPN_LSB +: sv39ptw_pkg::PPN_W];
    assign is_final = (state_cur.level == sv39ptw_pkg::LVL_0)
                   || ((2'd2 - state_cur.level) == state_cur.depth);

    always_comb
    begin
        state_next        = state_cur;
        result.kind       = sv39ptw_pkg::KIND_FAULT;
        result.phys_addr  = '0;
        result.fault_code = sv39ptw_pkg::FLT_NONE;

        if (func == sv39ptw_pkg::FUNC_REQUEST)
        begin
            if (va_oob)
            begin
                state_next.busy   = 1'b0;
                result.fault_code = sv39ptw_pkg::FLT_VA_RANGE;
            end
            else
            begin
                state_next.busy  = 1'b1;
                state_next.level = sv39ptw_pkg::LVL_2;
                state_next.va    = virt_addr;
                state_next.depth = stop_depth;
                result.kind      = sv39ptw_pkg::KIND_READ;
                result.phys_addr = sv39ptw_pkg::pte_address(root_ppn, sv39ptw_pkg::LVL_2,
                                                            virt_addr);
            end
        end
        else if (!state_cur.busy)
        begin
            result.fault_code = sv39ptw_pkg::FLT_UNEXP_RESP;
        end
        else if (is_final)
        begin
            state_next.busy = 1'b0;
            if (!pte_word[sv39ptw_pkg::PTE_VALID_BIT])
                result.fault_code = sv39ptw_pkg::FLT_LEAF_INVAL;
            else if (!pte_word[sv39ptw_pkg::PTE_USER_BIT])
                result.fault_code = sv39ptw_pkg::FLT_NOT_USER;
            else
            begin
                result.kind      = sv39ptw_pkg::KIND_DONE;
                result.phys_addr = {pte_ppn, {sv39ptw_pkg::PAGE_SHIFT{1'b0}}};
            end
        end
        else if (!pte_word[sv39ptw_pkg::PTE_VALID_BIT])
        begin
            state_next.busy   = 1'b0;
            result.fault_code = sv39ptw_pkg::FLT_NO_TABLE;
        end
        else
        begin
            state_next.level = lvl_dec;
            result.kind      = sv39ptw_pkg::KIND_READ;
            result.phys_addr = sv39ptw_pkg::pte_address(pte_ppn, lvl_dec, state_cur.va);
        end
    end

endmodule

@@ rtl/core/sv39_page_table_walker_unit.sv @@
// Top level of the Sv39 page table walker: configuration register, walk
// state, result register. Depends on sv39ptw_pkg, sv39ptw_if, sv39ptw_step.

// Usage:
//   in_chan carries two sorts of beat. func = 0 opens a lookup for virt_addr
//   with stop_depth (0, 1, 2 end at the level-2, -1, -0 table; 3 acts as 2).
//   func = 1 hands back the PTE that memory returned for the last read.
//   out_chan gives exactly one result beat per input beat: a PTE read
//   request (kind 0, phys_addr = PTE address), a finished translation
//   (kind 1, phys_addr = page base) or a fault (kind 2, fault_code).
//   A new lookup while a walk is open drops that walk.
//   cfg_wr_en / cfg_wr_data load the root table PPN; write it only while idle.
// Timing:
//   Each beat is decoded by one short combinational step (index select,
//   two flag checks, address form) into the result register, so a result
//   appears in the cycle after acceptance; one beat per cycle while out_chan.ready is high.
//   in_chan.ready is high whenever the result register is empty or being
//   drained in the same cycle; a stalled receiver holds the result and, one
//   beat later, stalls the input side too.
// Reset:
//   rst_n low clears the result valid flag, the walk state (idle) and the
//   root PPN to zero; the result payload is not reset.

module sv39_page_table_walker_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sv39ptw_pkg::PPN_W-1:0]     cfg_wr_data,
    sv39ptw_in_if.sink                        in_chan,
    sv39ptw_out_if.source                     out_chan
);

    logic [sv39ptw_pkg::PPN_W-1:0]  root_ppn_reg;
    sv39ptw_pkg::walk_state_t       state_reg;
    sv39ptw_pkg::walk_state_t       state_next;
    sv39ptw_pkg::walk_result_t      result_next;
    sv39ptw_pkg::walk_result_t      result_reg;
    logic                           out_valid_reg;
    logic                           in_fire;

    // Take a beat when the result slot is free or drains this cycle
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign in_fire       = in_chan.valid && in_chan.ready;

    sv39ptw_step u_step
    (
        .func       (in_chan.func),
        .virt_addr  (in_chan.virt_addr),
        .stop_depth (in_chan.stop_depth),
        .pte_word   (in_chan.pte_word),
        .root_ppn   (root_ppn_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Root table register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_ppn_reg <= '0;
        else if (cfg_wr_en)
            root_ppn_reg <= cfg_wr_data;
    end

    // Walk state: advance only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

    // Result valid: set on accept, drop when taken without a new beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.kind       = result_reg.kind;
    assign out_chan.phys_addr  = result_reg.phys_addr;
    assign out_chan.fault_code = result_reg.fault_code;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the Sv39 page table walker: lookup and PTE beats in,
// one result beat out per beat in, checked against an in-bench walk predictor.
// Depends on sv39ptw_pkg, the sv39ptw_in_if / sv39ptw_out_if channels and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import sv39ptw_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int QUIET_LIMIT = 5000;  // cycles with no beat moving before giving up
    localparam int SETTLE      = 4;     // settling wait before the final verdict

    // One beat offered on the input channel
    typedef struct {
        logic              func;
        logic [VA_W-1:0]   virt_addr;
        logic [1:0]        stop_depth;
        logic [PTE_W-1:0]  pte_word;
    } lookup_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [PPN_W-1:0] cfg_wr_data;

    sv39ptw_in_if  in_if ();
    sv39ptw_out_if out_if ();

    sv39_page_table_walker_unit u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (in_if),
        .out_chan    (out_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Beats waiting to be offered, and results owed by the block, oldest first
    lookup_beat_t  lookup_beats[$];
    walk_result_t  walk_expected[$];
    lookup_beat_t  beat_on_bus;

    // Predictor copy of the root pointer and of the open walk
    logic [PPN_W-1:0] mdl_root_ppn;
    logic             mdl_busy;
    logic [1:0]       mdl_level;
    logic [VA_W-1:0]  mdl_va;
    logic [1:0]       mdl_depth;

    // Idle shaping, set per phase by the stimulus process
    int src_idle_pct;
    int snk_idle_pct;
    int src_gap_left;
    int snk_gap_left;
    int holds_asked;
    int holds_done;
    int hold_left;
    int quiet_cycles;
    int mismatches;

    // Nine-bit table index of a virtual address at a given level
    function automatic logic [VPN_IDX_W-1:0] table_slot(input logic [1:0] lvl,
                                                        input logic [VA_W-1:0] va);
        return VPN_IDX_W'(va >> (PAGE_SHIFT + VPN_IDX_W * int'(lvl)));
    endfunction

    // Advance the predicted walk by one accepted beat and return the result owed
    function automatic walk_result_t translate_beat(input lookup_beat_t b);
        walk_result_t r;
        r = '0;
        if (b.func == FUNC_REQUEST)
        begin
            if ((b.virt_addr >> VA_BITS) != 0)
            begin
                // Address beyond the walker's range: fault at once, stay idle
                mdl_busy     = 1'b0;
                r.kind       = KIND_FAULT;
                r.fault_code = FLT_VA_RANGE;
            end
            else
            begin
                // New lookup; drop any walk still open and read the root entry
                mdl_busy    = 1'b1;
                mdl_level   = LVL_2;
                mdl_va      = b.virt_addr;
                mdl_depth   = b.stop_depth;
                r.kind      = KIND_READ;
                r.phys_addr = {mdl_root_ppn, table_slot(LVL_2, b.virt_addr), 3'b000};
            end
        end
        else if (!mdl_busy)
        begin
            r.kind       = KIND_FAULT;
            r.fault_code = FLT_UNEXP_RESP;
        end
        else if (mdl_level == LVL_0 || (2'd2 - mdl_level) == mdl_depth)
        begin
            // Final entry: must be valid, then user-accessible
            mdl_busy = 1'b0;
            if (!b.pte_word[PTE_VALID_BIT])
            begin
                r.kind       = KIND_FAULT;
                r.fault_code = FLT_LEAF_INVAL;
            end
            else if (!b.pte_word[PTE_USER_BIT])
            begin
                r.kind       = KIND_FAULT;
                r.fault_code = FLT_NOT_USER;
            end
            else
            begin
                r.kind      = KIND_DONE;
                r.phys_addr = {b.pte_word[PTE_PPN_LSB +: PPN_W], 12'h000};
            end
        end
        else if (!b.pte_word[PTE_VALID_BIT])
        begin
            mdl_busy     = 1'b0;
            r.kind       = KIND_FAULT;
            r.fault_code = FLT_NO_TABLE;
        end
        else
        begin
            // Upper entry: only the valid bit counts, leaf bits are ignored
            mdl_level   = mdl_level - 2'd1;
            r.kind      = KIND_READ;
            r.phys_addr = {b.pte_word[PTE_PPN_LSB +: PPN_W], table_slot(mdl_level, mdl_va),
                           3'b000};
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic add_beat(input logic func, input logic [VA_W-1:0] va,
                            input logic [1:0] depth, input logic [PTE_W-1:0] pte);
        lookup_beat_t b;
        b.func       = func;
        b.virt_addr  = va;
        b.stop_depth = depth;
        b.pte_word   = pte;
        lookup_beats.push_back(b);
    endtask

    task automatic note_mismatch(input string what, input walk_result_t want,
                                 input walk_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected kind=%0d pa=%h fault=%0d, %s%0d pa=%h fault=%0d",
                     $time, what, want.kind, want.phys_addr, want.fault_code,
                     "got kind=", got.kind, got.phys_addr, got.fault_code);
    endtask

    // Wait, on falling edges, until every beat has gone in and every result come out
    task automatic wait_walks_settled();
        do
            @(negedge clk);
        while (lookup_beats.size() != 0 || in_if.valid || walk_expected.size() != 0);
    endtask

    // Load the root pointer while the block is quiet
    task automatic write_root(input logic [PPN_W-1:0] ppn);
        @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= ppn;
        mdl_root_ppn = ppn;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Queue random traffic: mostly complete walks with random content, the rest
    // stray responses, out-of-range lookups and walks cut short
    task automatic queue_random(input int n);
        int added;
        int pick;
        int n_resp;
        logic [VA_W-1:0]  va;
        logic [1:0]       depth;
        logic [PTE_W-1:0] pte;
        added = 0;
        while (added < n)
        begin
            pick  = $urandom_range(0, 99);
            va    = VA_W'(rand64());
            depth = 2'($urandom_range(0, 3));
            if (pick < 93)
                va = va & ((39'd1 << VA_BITS) - 39'd1);
            if (pick < 80)
            begin
                n_resp = (depth == 2'd3) ? 3 : int'(depth) + 1;
                add_beat(FUNC_REQUEST, va, depth, rand64());
                for (int k = 1; k <= n_resp; k++)
                begin
                    pte = rand64();
                    if (k < n_resp)
                    begin
                        if ($urandom_range(0, 9) != 0)
                            pte[PTE_VALID_BIT] = 1'b1;
                    end
                    else if ($urandom_range(0, 4) != 0)
                    begin
                        pte[PTE_VALID_BIT] = 1'b1;
                        pte[PTE_USER_BIT]  = 1'b1;
                    end
                    add_beat(FUNC_RESPONSE, VA_W'(rand64()), 2'($urandom_range(0, 3)), pte);
                end
                added += n_resp + 1;
            end
            else if (pick < 87)
            begin
                add_beat(FUNC_RESPONSE, va, depth, rand64());
                added++;
            end
            else if (pick < 93)
            begin
                // Cut a walk short; the next lookup drops it
                n_resp = $urandom_range(0, 1);
                add_beat(FUNC_REQUEST, va, depth, rand64());
                if (n_resp != 0)
                    add_beat(FUNC_RESPONSE, VA_W'(rand64()), depth,
                             rand64() | 64'(1 << PTE_VALID_BIT));
                added += n_resp + 1;
            end
            else
            begin
                va[VA_W-1] = 1'b1;
                add_beat(FUNC_REQUEST, va, depth, rand64());
                added++;
            end
        end
    endtask

    // Input driver: offer queued beats, hold a beat until it is taken,
    // and predict the result of each beat at the edge where it is accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_lookups
        if (!rst_n)
        begin
            in_if.valid  <= 1'b0;
            src_gap_left = 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
                walk_expected.push_back(translate_beat(beat_on_bus));
            // Hold the beat while the block stalls; otherwise idle or advance
            if (!(in_if.valid && !in_if.ready))
            begin
                if (src_gap_left != 0)
                begin
                    src_gap_left--;
                    in_if.valid <= 1'b0;
                end
                else if (lookup_beats.size() != 0)
                begin
                    beat_on_bus = lookup_beats.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.func       <= beat_on_bus.func;
                    in_if.virt_addr  <= beat_on_bus.virt_addr;
                    in_if.stop_depth <= beat_on_bus.stop_depth;
                    in_if.pte_word   <= beat_on_bus.pte_word;
                    if ($urandom_range(0, 99) < src_idle_pct)
                        src_gap_left = gap_len();
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to obey it
    always @(posedge clk or negedge rst_n)
    begin : hold_results
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Output monitor: check each accepted result beat, then choose next ready
    always @(posedge clk or negedge rst_n)
    begin : check_results
        walk_result_t got;
        walk_result_t want;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            snk_gap_left = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                got.kind       = out_if.kind;
                got.phys_addr  = out_if.phys_addr;
                got.fault_code = out_if.fault_code;
                if (walk_expected.size() == 0)
                begin
                    note_mismatch("result with nothing owed", '0, got);
                end
                else
                begin
                    want = walk_expected.pop_front();
                    if (got.kind !== want.kind || got.phys_addr !== want.phys_addr ||
                        got.fault_code !== want.fault_code)
                        note_mismatch("wrong result", want, got);
                end
            end
            if (hold_left != 0)
            begin
                out_if.ready <= 1'b0;
            end
            else if (snk_gap_left != 0)
            begin
                snk_gap_left--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < snk_idle_pct)
                    snk_gap_left = gap_len();
            end
        end
    end

    // Watchdog: give up once no beat has moved for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n === 1'b1)
        begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles, %0d results owed",
                         quiet_cycles, walk_expected.size());
                $display("sv39_page_table_walker_unit: mismatch");
                $finish;
            end
        end
    end

    // Stimulus: reset, a directed walk-through, then random phases, each under a
    // different root pointer and idle mix, with a full drain before every write
    initial
    begin : stimulus
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_REQUEST;
        in_if.virt_addr  = '0;
        in_if.stop_depth = 2'd0;
        in_if.pte_word   = '0;
        out_if.ready     = 1'b0;
        mdl_root_ppn     = '0;
        mdl_busy         = 1'b0;
        mdl_level        = LVL_0;
        mdl_va           = '0;
        mdl_depth        = 2'd0;
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        holds_asked      = 0;
        quiet_cycles     = 0;
        mismatches       = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk-through with the root pointer left at its reset value
        src_idle_pct = 25;
        snk_idle_pct = 25;
        add_beat(FUNC_RESPONSE, '1, 2'd3, '1);                       // response while idle
        add_beat(FUNC_REQUEST, '1, 2'd2, '0);                        // address out of range
        add_beat(FUNC_REQUEST, 39'h40_0000_0000, 2'd0, '0);          // first address out of range
        add_beat(FUNC_REQUEST, 39'h3F_FFFF_FFFF, 2'd2, '1);          // highest legal address
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h1);
        add_beat(FUNC_RESPONSE, '0, 2'd0, '1);
        add_beat(FUNC_RESPONSE, '0, 2'd0, '1);                       // 4 KiB page done
        add_beat(FUNC_REQUEST, '0, 2'd0, '0);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h11);                   // 1 GiB page done
        add_beat(FUNC_REQUEST, 39'h12_3456_789A, 2'd1, '0);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'hF);                    // leaf bits on upper entry
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h1);                    // final entry not user
        add_beat(FUNC_REQUEST, 39'h2A_AAAA_AAAA, 2'd3, '0);          // stop depth three
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h0015_5555_5555_5401);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h1);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h10);                   // final entry invalid
        add_beat(FUNC_REQUEST, 39'h15_5555_5555, 2'd2, '0);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h0);                    // missing table
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h11);                   // idle again after fault
        add_beat(FUNC_REQUEST, 39'h3F_0000_1000, 2'd2, '0);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'hFFC0_0000_0000_0001);
        add_beat(FUNC_REQUEST, 39'h01_0203_0405, 2'd0, '0);          // lookup while busy
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'hC03F_FFFF_FFFF_FC11);
        add_beat(FUNC_RESPONSE, '0, 2'd0, 64'h11);
        wait_walks_settled();

        // Highest root, with the long hold-off so the input side backs up
        write_root('1);
        src_idle_pct = 20;
        snk_idle_pct = 20;
        holds_asked  = holds_asked + 1;
        queue_random(320);
        wait_walks_settled();

        // Zero root, no idling on either side
        write_root('0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(300);
        wait_walks_settled();

        write_root(PPN_W'(rand64()));
        src_idle_pct = 40;
        snk_idle_pct = 10;
        queue_random(300);
        wait_walks_settled();

        write_root(PPN_W'(rand64()));
        src_idle_pct = 10;
        snk_idle_pct = 50;
        queue_random(300);
        wait_walks_settled();

        write_root(PPN_W'(1));
        src_idle_pct = 30;
        snk_idle_pct = 30;
        queue_random(300);
        wait_walks_settled();

        write_root(PPN_W'(rand64()));
        src_idle_pct = 0;
        snk_idle_pct = 30;
        queue_random(300);
        wait_walks_settled();

        // Let any stray beat surface before the verdict
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && walk_expected.size() == 0)
            $display("sv39_page_table_walker_unit: match");
        else
            $display("sv39_page_table_walker_unit: mismatch");
        $finish;
    end

endmodule
